// ===== rtl/core/graphic_lcd_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the graphic LCD controller
// Short forms for clocked implications with a reset guard. They sample on
// i_clk and are held off while i_rst_n is low, both taken from the module
// that uses them.
// ----------------------------------------------------------------------------
`ifndef GRAPHIC_LCD_CONTROLLER_MACROS_SVH
`define GRAPHIC_LCD_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define GLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/glc_pkg.sv =====
// ----------------------------------------------------------------------------
// glc_pkg
// Types, geometry and command codes shared by the graphic LCD controller.
// ----------------------------------------------------------------------------
package glc_pkg;

    localparam int COLUMNS  = 132;
    localparam int PAGES    = 9;
    localparam int ROWS     = 65;
    localparam int RAM_SIZE = PAGES * COLUMNS;

    localparam int RAM_AW   = $clog2(RAM_SIZE);
    // Wide enough for any page code times COLUMNS plus any column code.
    localparam int FULL_AW  = $clog2(15 * COLUMNS + 256);

    localparam logic [7:0]  COL_LAST    = 8'(COLUMNS - 1);
    localparam logic [6:0]  ROW_SHIFT   = 7'(ROWS - (32 % ROWS));
    localparam logic [10:0] BUSY_RESET  = 11'd1520;
    localparam logic [10:0] BUSY_WRITE  = 11'd41;

    localparam logic [7:0] CMD_RESET      = 8'hE2;
    localparam logic [7:0] CMD_DISPLAY    = 8'hAE;
    localparam logic [7:0] CMD_START_LINE = 8'h40;
    localparam logic [7:0] CMD_PAGE       = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;
    localparam logic [7:0] CMD_COL_LOW    = 8'h00;
    localparam logic [7:0] CMD_ADC        = 8'hA0;
    localparam logic [7:0] CMD_REVERSE    = 8'hA6;
    localparam logic [7:0] CMD_ENTIRE     = 8'hA4;
    localparam logic [7:0] CMD_RMW_ENTER  = 8'hE0;
    localparam logic [7:0] CMD_RMW_EXIT   = 8'hEE;
    localparam logic [7:0] MASK_PAIR      = 8'hFE;
    localparam logic [7:0] MASK_START     = 8'hC0;
    localparam logic [7:0] MASK_NIBBLE    = 8'hF0;
    localparam logic [7:0] STATUS_BUSY    = 8'h80;

    typedef enum logic [2:0] {
        OP_CMD_WRITE  = 3'd0,
        OP_STATUS     = 3'd1,
        OP_DATA_WRITE = 3'd2,
        OP_DATA_READ  = 3'd3,
        OP_PIXEL      = 3'd4,
        OP_TICK       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_CMD_WRITE  = 2'd0,
        KIND_STATUS     = 2'd1,
        KIND_DATA_WRITE = 2'd2,
        KIND_DATA_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    function automatic logic [FULL_AW-1:0] ram_addr(input logic [3:0] page,
                                                    input logic [7:0] col);
        ram_addr = FULL_AW'(page) * FULL_AW'(COLUMNS) + FULL_AW'(col);
    endfunction

endpackage

// ===== rtl/core/graphic_lcd_controller.sv =====
// ----------------------------------------------------------------------------
// graphic_lcd_controller
// Command-set compatible graphic LCD controller with 9 x 132 byte display RAM.
// ----------------------------------------------------------------------------
// Each request is done in the idle and execute states: the cycle it is
// accepted issues the display RAM read, and the execute state updates the
// state, writes the RAM if needed and loads the output register. A stalled
// output holds the execute state. After reset, and after each reset command,
// the RAM write port clears the whole RAM at one byte a cycle, during which
// no request is accepted; configuration writes are taken at any time.
module graphic_lcd_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,   // nibble_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,         // data_in[7:0], pixel_x[15:8], pixel_y[22:16]
    input  logic [2:0]  s_tuser,         // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata          // read_data[7:0], busy_res[8], pixel[9],
                                         // display_on[10], reverse_video[11],
                                         // entire_on[12]
);

    glc_pkg::t_state r_state, n_state;

    logic                        r_nibble_mode;
    logic [3:0]                  r_page, n_page;
    logic [7:0]                  r_col, n_col;
    logic [7:0]                  r_saved_col, n_saved_col;
    logic [7:0]                  r_cmd, n_cmd;
    logic [7:0]                  r_data, n_data;
    logic [5:0]                  r_start, n_start;
    logic                        r_display, n_display;
    logic                        r_adc, n_adc;
    logic                        r_reverse, n_reverse;
    logic                        r_entire, n_entire;
    logic                        r_rmw, n_rmw;
    logic                        r_phase, n_phase;
    glc_pkg::t_kind              r_kind, n_kind;
    logic [10:0]                 r_busy, n_busy;
    logic [glc_pkg::RAM_AW-1:0]  r_clr_addr;

    // Accepted request.
    logic [2:0]                  r_op;
    logic [7:0]                  r_din;
    logic [2:0]                  r_pix_bit;
    logic                        r_pix_ok;

    logic                        r_out_valid;
    logic [15:0]                 r_out_data, n_out_data;

    logic                        w_accept;
    logic                        w_fire;
    logic                        w_clear_req;
    logic                        w_clear_done;
    logic                        w_step_phase;
    logic [glc_pkg::FULL_AW-1:0] w_cur_addr;
    logic                        w_cur_ok;

    // Pixel address path.
    logic [7:0]                  w_px;
    logic [6:0]                  w_py;
    logic [7:0]                  w_col_pix;
    logic [7:0]                  w_sum;
    logic [7:0]                  w_row1;
    logic [7:0]                  w_row2;
    logic [6:0]                  w_row;
    logic [glc_pkg::FULL_AW-1:0] w_pix_addr;
    logic                        w_pix_ok;

    logic                        w_ram_we;
    logic [glc_pkg::RAM_AW-1:0]  w_ram_waddr;
    logic [7:0]                  w_ram_wdata;
    logic                        w_ram_re;
    logic [glc_pkg::RAM_AW-1:0]  w_ram_raddr;
    logic [7:0]                  w_ram_rdata;
    logic                        w_exec_we;

    assign w_accept     = s_tvalid && s_tready;
    assign w_fire       = (r_state == glc_pkg::ST_EXEC) && (!r_out_valid || m_tready);
    assign w_clear_done = (r_clr_addr == glc_pkg::RAM_AW'(glc_pkg::RAM_SIZE - 1));
    assign w_cur_addr   = glc_pkg::ram_addr(r_page, r_col);
    assign w_cur_ok     = (w_cur_addr < glc_pkg::FULL_AW'(glc_pkg::RAM_SIZE));

    // Screen position to RAM address; the row sum stays below three times ROWS.
    always_comb begin
        w_px      = s_tdata[15:8];
        w_py      = s_tdata[22:16];
        w_col_pix = r_adc ? w_px : (glc_pkg::COL_LAST - w_px);
        w_sum     = 8'(w_py) + 8'(r_start);
        if (w_sum >= 8'(2 * glc_pkg::ROWS)) begin
            w_row1 = w_sum - 8'(2 * glc_pkg::ROWS);
        end else if (w_sum >= 8'(glc_pkg::ROWS)) begin
            w_row1 = w_sum - 8'(glc_pkg::ROWS);
        end else begin
            w_row1 = w_sum;
        end
        w_row2 = w_row1 + 8'(glc_pkg::ROW_SHIFT);
        if (w_row2 >= 8'(glc_pkg::ROWS)) begin
            w_row = 7'(w_row2 - 8'(glc_pkg::ROWS));
        end else begin
            w_row = 7'(w_row2);
        end
        w_pix_addr = glc_pkg::ram_addr(w_row[6:3], w_col_pix);
        w_pix_ok   = (w_px < 8'(glc_pkg::COLUMNS))
                  && (w_pix_addr < glc_pkg::FULL_AW'(glc_pkg::RAM_SIZE));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            glc_pkg::ST_CLEAR: begin
                if (w_clear_done) begin
                    n_state = glc_pkg::ST_IDLE;
                end
            end
            glc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_state = glc_pkg::ST_EXEC;
                end
            end
            glc_pkg::ST_EXEC: begin
                if (w_fire) begin
                    n_state = w_clear_req ? glc_pkg::ST_CLEAR : glc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = glc_pkg::ST_CLEAR;
            end
        endcase
    end

    // State machine outputs: handshake and RAM port control.
    always_comb begin
        s_tready    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr_addr;
        w_ram_wdata = 8'h00;
        case (r_state)
            glc_pkg::ST_CLEAR: begin
                w_ram_we = 1'b1;
            end
            glc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                w_ram_re = s_tvalid;
            end
            glc_pkg::ST_EXEC: begin
                w_ram_we    = w_exec_we;
                w_ram_waddr = glc_pkg::RAM_AW'(w_cur_addr);
                w_ram_wdata = n_data;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign w_ram_raddr = (s_tuser == glc_pkg::OP_PIXEL) ? glc_pkg::RAM_AW'(w_pix_addr)
                                                        : glc_pkg::RAM_AW'(w_cur_addr);

    // The read is issued at accept and the write lands in the execute state, so
    // a request never reads an entry while it is being written.
    glc_ram #(
        .WIDTH (8),
        .DEPTH (glc_pkg::RAM_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Phase after a nibble step; any change of access kind restarts it.
    assign w_step_phase = (r_kind != glc_pkg::t_kind'(r_op[1:0])) ? 1'b1 : !r_phase;

    // Execution of the accepted request.
    always_comb begin
        logic       run;
        logic [7:0] rd;
        logic       pix;
        logic [7:0] v;
        logic [7:0] st;
        n_page      = r_page;
        n_col       = r_col;
        n_saved_col = r_saved_col;
        n_cmd       = r_cmd;
        n_data      = r_data;
        n_start     = r_start;
        n_display   = r_display;
        n_adc       = r_adc;
        n_reverse   = r_reverse;
        n_entire    = r_entire;
        n_rmw       = r_rmw;
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_busy      = r_busy;
        w_clear_req = 1'b0;
        w_exec_we   = 1'b0;
        run         = 1'b0;
        rd          = 8'h00;
        pix         = 1'b0;
        v           = w_ram_rdata;
        st          = (r_busy != 11'd0) ? glc_pkg::STATUS_BUSY : 8'h00;
        case (r_op)
            glc_pkg::OP_CMD_WRITE: begin
                if (r_nibble_mode) begin
                    n_phase = w_step_phase;
                    n_kind  = glc_pkg::KIND_CMD_WRITE;
                    if (w_step_phase) begin
                        n_cmd = {r_din[7:4], 4'h0};
                    end else begin
                        n_cmd = r_cmd | {4'h0, r_din[7:4]};
                        run   = 1'b1;
                    end
                end else begin
                    n_cmd = r_din;
                    run   = 1'b1;
                end
                if (run) begin
                    if (n_cmd == glc_pkg::CMD_RESET) begin
                        n_page      = 4'd0;
                        n_col       = 8'd0;
                        w_clear_req = 1'b1;
                    end else if ((n_cmd & glc_pkg::MASK_PAIR) == glc_pkg::CMD_DISPLAY) begin
                        n_display = n_cmd[0];
                    end else if ((n_cmd & glc_pkg::MASK_START) == glc_pkg::CMD_START_LINE) begin
                        n_start = n_cmd[5:0];
                    end else if ((n_cmd & glc_pkg::MASK_NIBBLE) == glc_pkg::CMD_PAGE) begin
                        n_page = n_cmd[3:0];
                    end else if ((n_cmd & glc_pkg::MASK_NIBBLE) == glc_pkg::CMD_COL_HIGH) begin
                        n_col = {n_cmd[3:0], r_col[3:0]};
                    end else if ((n_cmd & glc_pkg::MASK_NIBBLE) == glc_pkg::CMD_COL_LOW) begin
                        n_col = {r_col[7:4], n_cmd[3:0]};
                    end else if ((n_cmd & glc_pkg::MASK_PAIR) == glc_pkg::CMD_ADC) begin
                        n_adc = n_cmd[0];
                    end else if ((n_cmd & glc_pkg::MASK_PAIR) == glc_pkg::CMD_REVERSE) begin
                        n_reverse = n_cmd[0];
                    end else if ((n_cmd & glc_pkg::MASK_PAIR) == glc_pkg::CMD_ENTIRE) begin
                        n_entire = n_cmd[0];
                    end else if (n_cmd == glc_pkg::CMD_RMW_ENTER) begin
                        n_rmw       = 1'b1;
                        n_saved_col = r_col;
                    end else if (n_cmd == glc_pkg::CMD_RMW_EXIT) begin
                        n_rmw = 1'b0;
                        n_col = r_saved_col;
                    end
                end
            end
            glc_pkg::OP_STATUS: begin
                if (r_nibble_mode) begin
                    n_phase = w_step_phase;
                    n_kind  = glc_pkg::KIND_STATUS;
                    rd      = w_step_phase ? st : 8'h00;
                end else begin
                    rd = st;
                end
            end
            glc_pkg::OP_DATA_WRITE: begin
                run = 1'b1;
                if (r_nibble_mode) begin
                    n_phase = w_step_phase;
                    n_kind  = glc_pkg::KIND_DATA_WRITE;
                    if (w_step_phase) begin
                        n_data = {r_din[7:4], 4'h0};
                        run    = 1'b0;
                    end else begin
                        n_data = r_data | {4'h0, r_din[7:4]};
                    end
                end else begin
                    n_data = r_din;
                end
                if (run) begin
                    w_exec_we = w_fire && w_cur_ok;
                    if (r_col < glc_pkg::COL_LAST) begin
                        n_col = r_col + 8'd1;
                    end
                    n_busy = glc_pkg::BUSY_WRITE;
                end
            end
            glc_pkg::OP_DATA_READ: begin
                // An address beyond the RAM leaves everything as it is.
                if (w_cur_ok) begin
                    if (!r_rmw && (r_col < glc_pkg::COL_LAST)) begin
                        n_col = r_col + 8'd1;
                    end
                    if (r_nibble_mode) begin
                        n_phase = w_step_phase;
                        n_kind  = glc_pkg::KIND_DATA_READ;
                        v       = w_step_phase ? {w_ram_rdata[7:4], 4'h0}
                                               : {w_ram_rdata[3:0], 4'h0};
                    end
                    rd = v;
                end
            end
            glc_pkg::OP_PIXEL: begin
                pix = r_pix_ok && w_ram_rdata[r_pix_bit];
            end
            glc_pkg::OP_TICK: begin
                if (r_busy != 11'd0) begin
                    n_busy = r_busy - 11'd1;
                end
            end
            default: begin
                rd = 8'h00;
            end
        endcase
        n_out_data = {3'b000, n_entire, n_reverse, n_display, pix,
                      (n_busy != 11'd0), rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= glc_pkg::ST_CLEAR;
            r_nibble_mode <= 1'b0;
            r_page        <= 4'd0;
            r_col         <= 8'd0;
            r_cmd         <= 8'h00;
            r_data        <= 8'h00;
            r_start       <= 6'd0;
            r_display     <= 1'b0;
            r_adc         <= 1'b1;
            r_reverse     <= 1'b0;
            r_entire      <= 1'b0;
            r_rmw         <= 1'b0;
            r_phase       <= 1'b0;
            r_kind        <= glc_pkg::KIND_CMD_WRITE;
            r_busy        <= glc_pkg::BUSY_RESET;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_nibble_mode <= i_cfg_wr_data;
            end
            if (r_state == glc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + glc_pkg::RAM_AW'(1);
            end else begin
                r_clr_addr <= '0;
            end
            if (w_fire) begin
                r_page      <= n_page;
                r_col       <= n_col;
                r_cmd       <= n_cmd;
                r_data      <= n_data;
                r_start     <= n_start;
                r_display   <= n_display;
                r_adc       <= n_adc;
                r_reverse   <= n_reverse;
                r_entire    <= n_entire;
                r_rmw       <= n_rmw;
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_busy      <= n_busy;
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= s_tuser;
            r_din     <= s_tdata[7:0];
            r_pix_bit <= w_row[2:0];
            r_pix_ok  <= w_pix_ok;
        end
        if (w_fire) begin
            r_saved_col <= n_saved_col;
            r_out_data  <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== rtl/core/glc_ram.sv =====
// ----------------------------------------------------------------------------
// glc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module glc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/glc_checker.sv =====
// ----------------------------------------------------------------------------
// glc_checker
// Port-level checks for the graphic LCD controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "graphic_lcd_controller_macros.svh"

module glc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic w_stall;
    logic w_pixel_out;

    assign w_stall     = m_tvalid && !m_tready;
    assign w_pixel_out = m_tvalid && m_tdata[9];

    // A stalled result must not change.
    `GLC_ASSERT_NEXT(a_out_hold, w_stall, m_tvalid && $stable(m_tdata), "result moved")

    // Only one request is in work at a time.
    `GLC_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "second request in work")

    // A pixel answer carries no read byte, since only a pixel query sets it.
    `GLC_ASSERT_NOW(a_pixel_alone, w_pixel_out, m_tdata[7:0] == 8'h00, "pixel with read byte")

    // Padding above the flags stays zero.
    `GLC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:13] == 3'b000, "padding bits set")

endmodule

bind graphic_lcd_controller glc_checker u_glc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
